>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, quiet while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

>>> hdl/s2l_pkg.sv
`timescale 1ns / 1ps
package s2l_pkg;

   localparam int LIN_W = 31;
   localparam int V_W   = 32;
   localparam int F_W   = 32;
   localparam int NUM_W = 48;

   localparam int ROOT_W   = 31;
   localparam int DIV_BITS = 4;

   localparam int DIV_LAT = NUM_W / DIV_BITS;
   localparam int CMP_LAT = 2 * ROOT_W + 2;
   localparam int TOTAL_LAT = 3 + DIV_LAT + CMP_LAT + 2;

   localparam logic [F_W-1:0] F_OFFSET = F_W'(64'd17179869184 / 64'd116);

   typedef logic [LIN_W-1:0] lin_table_type [256];

   function automatic logic [63:0] pow5_q30(input logic [63:0] r);
      logic [63:0] r2;
      logic [63:0] r4;
      r2 = (r * r) >> 30;
      r4 = (r2 * r2) >> 30;
      return (r4 * r) >> 30;
   endfunction

   function automatic logic [63:0] lin_entry(input logic [63:0] c);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      if (100000 * c > 64'd1031475) begin
         t  = ((1000 * c + 64'd14025) << 30) / 64'd269025;
         t2 = (t * t) >> 30;
         for (int bit_i = 30; bit_i >= 0; bit_i--) begin
            cand = r | (64'd1 << bit_i);
            if (cand <= (64'd1 << 30) && pow5_q30(cand) <= t2) begin
               r = cand;
            end
         end
         return (t2 * r) >> 30;
      end
      return ((10 * c) << 30) / 64'd32946;
   endfunction

   function automatic lin_table_type build_lin_table();
      lin_table_type tab;
      for (int c = 0; c < 256; c++) begin
         tab[c] = LIN_W'(lin_entry(64'(c)));
      end
      return tab;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

>>> hdl/s2l_cdiv.sv
`timescale 1ns / 1ps
module s2l_cdiv #(
   parameter int NUM_W   = 48,
   parameter int QUO_W   = 32,
   parameter int DIVISOR = 3
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   output logic [QUO_W-1:0] quo_out
);
   localparam int REM_W  = $clog2(DIVISOR) + 1;
   localparam int BITS   = s2l_pkg::DIV_BITS;
   localparam int STAGES = NUM_W / BITS;

   logic [REM_W-1:0] rem_ff [STAGES];
   logic [NUM_W-1:0] num_ff [STAGES];
   logic [NUM_W-1:0] quo_ff [STAGES];
   logic [REM_W-1:0] rem_in [STAGES];
   logic [NUM_W-1:0] num_in_s [STAGES];
   logic [NUM_W-1:0] quo_in [STAGES];

   // Restoring long division, four quotient bits per stage.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [REM_W-1:0] rem_src;
      logic [NUM_W-1:0] num_src;
      logic [NUM_W-1:0] quo_src;
      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = num_in;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign num_src = num_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      always_comb begin : p_step
         logic [REM_W-1:0] rem;
         logic [NUM_W-1:0] num;
         logic [NUM_W-1:0] quo;
         rem = rem_src;
         num = num_src;
         quo = quo_src;
         for (int j = 0; j < BITS; j++) begin
            rem = {rem[REM_W-2:0], num[NUM_W-1]};
            num = num << 1;
            quo = quo << 1;
            if (rem >= REM_W'(DIVISOR)) begin
               rem = rem - REM_W'(DIVISOR);
               quo[0] = 1'b1;
            end
         end
         rem_in[s]   = rem;
         num_in_s[s] = num;
         quo_in[s]   = quo;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            num_ff[s] <= num_in_s[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo_out = quo_ff[STAGES-1][QUO_W-1:0];
endmodule

>>> hdl/s2l_compand.sv
`timescale 1ns / 1ps
module s2l_compand (
   input  logic                    clock,
   input  logic                    en,
   input  logic [s2l_pkg::V_W-1:0] v_in,
   output logic [s2l_pkg::F_W-1:0] f_out
);
   localparam int RB = s2l_pkg::ROOT_W;
   localparam int LIN_DELAY = 2 * RB - s2l_pkg::DIV_LAT;

   logic [s2l_pkg::V_W-1:0]   v0_ff;
   logic                      flag0_ff;
   logic [s2l_pkg::NUM_W-1:0] lnum_ff;
   logic [s2l_pkg::F_W-1:0]   lq;

   always_ff @(posedge clock) begin
      if (en) begin
         v0_ff    <= v_in;
         flag0_ff <= (52'(v_in) * 52'd1000000) > (52'd8856 << 30);
         lnum_ff  <= s2l_pkg::NUM_W'(v_in) * s2l_pkg::NUM_W'(7787);
      end
   end

   s2l_cdiv #(
      .NUM_W  (s2l_pkg::NUM_W),
      .QUO_W  (s2l_pkg::F_W),
      .DIVISOR(1000)
   ) u_lin_div (
      .clock  (clock),
      .en     (en),
      .num_in (lnum_ff),
      .quo_out(lq)
   );

   logic [RB-1:0]           cand_c  [RB];
   logic [RB-1:0]           cand_ff [RB];
   logic [2*RB-1:0]         sq_ff   [RB];
   logic [s2l_pkg::V_W-1:0] va_ff   [RB];
   logic [s2l_pkg::V_W-1:0] vb_ff   [RB];
   logic [RB-1:0]           r_ff    [RB];

   // Cube root by bit search: one stage squares the candidate, the next cubes and compares.
   for (genvar i = 0; i < RB; i++) begin : g_root
      localparam int B = RB - 1 - i;
      logic [RB-1:0]           r_prev;
      logic [s2l_pkg::V_W-1:0] v_prev;
      logic [31:0]             r2;
      logic [62:0]             cube;
      if (i == 0) begin : g_first
         assign r_prev = '0;
         assign v_prev = v0_ff;
      end else begin : g_next
         assign r_prev = r_ff[i-1];
         assign v_prev = vb_ff[i-1];
      end
      assign cand_c[i] = r_prev | (RB'(1) << B);
      assign r2   = sq_ff[i][61:30];
      assign cube = 63'(r2) * 63'(cand_ff[i]);

      always_ff @(posedge clock) begin
         if (en) begin
            cand_ff[i] <= cand_c[i];
            sq_ff[i]   <= (2*RB)'(cand_c[i]) * (2*RB)'(cand_c[i]);
            va_ff[i]   <= v_prev;
            vb_ff[i]   <= va_ff[i];
            if (cube[62:30] <= {1'b0, va_ff[i]}) begin
               r_ff[i] <= cand_ff[i];
            end else begin
               r_ff[i] <= cand_ff[i] & ~(RB'(1) << B);
            end
         end
      end
   end

   logic                    flag_d [2*RB];
   logic [s2l_pkg::F_W-1:0] lin_d  [LIN_DELAY];
   logic [s2l_pkg::F_W-1:0] f_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         flag_d[0] <= flag0_ff;
         for (int k = 1; k < 2*RB; k++) begin
            flag_d[k] <= flag_d[k-1];
         end
         lin_d[0] <= lq;
         for (int k = 1; k < LIN_DELAY; k++) begin
            lin_d[k] <= lin_d[k-1];
         end
         if (flag_d[2*RB-1]) begin
            f_ff <= s2l_pkg::F_W'(r_ff[RB-1]);
         end else begin
            f_ff <= lin_d[LIN_DELAY-1] + s2l_pkg::F_OFFSET;
         end
      end
   end

   assign f_out = f_ff;
endmodule

>>> hdl/srgb_to_cielab.sv
`timescale 1ns / 1ps
// sRGB to CIELAB (D65, 2-degree observer) pixel converter.
// The request channel carries one sRGB pixel, 8 bits per channel, per beat on
// req_red, req_green and req_blue; the response channel returns L unsigned and
// a and b signed, in fixed point with 8 fraction bits. Every request beat yields
// exactly one response beat, in order.
// Throughput is one pixel per clock while no response beat is stalled. An
// accepted request beat passes through the linearisation table, the colour
// matrix, the constant dividers that normalise by the white point, the cube
// root search (two stages per result bit) and scaling, rounding and clamping.
// The pipeline advances as a whole. While a response beat is offered and
// rsp_stall is high, every stage holds and req_stall is raised, so nothing
// is lost or repeated. Synchronous reset clears all valid bits; the data
// path registers are not reset.
module srgb_to_cielab (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_lightness,
   output logic [15:0] rsp_green_red_axis,
   output logic [15:0] rsp_blue_yellow_axis
);
   localparam int LW = s2l_pkg::LIN_W;
   localparam int PW = LW + 14;

   logic en;
   logic valid_ff [s2l_pkg::TOTAL_LAT];

   assign en        = !(valid_ff[s2l_pkg::TOTAL_LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[s2l_pkg::TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < s2l_pkg::TOTAL_LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < s2l_pkg::TOTAL_LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   logic [LW-1:0] lr_ff, lg_ff, lb_ff;
   logic [PW-1:0] pxr_ff, pxg_ff, pxb_ff, pyr_ff, pyg_ff, pyb_ff;
   logic [PW-1:0] pzr_ff, pzg_ff, pzb_ff;
   logic [s2l_pkg::NUM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic [s2l_pkg::NUM_W-1:0] sx, sz;

   assign sx = s2l_pkg::NUM_W'(pxr_ff) + s2l_pkg::NUM_W'(pxg_ff) + s2l_pkg::NUM_W'(pxb_ff);
   assign sz = s2l_pkg::NUM_W'(pzr_ff) + s2l_pkg::NUM_W'(pzg_ff) + s2l_pkg::NUM_W'(pzb_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         lr_ff  <= s2l_pkg::LIN_TABLE[req_red];
         lg_ff  <= s2l_pkg::LIN_TABLE[req_green];
         lb_ff  <= s2l_pkg::LIN_TABLE[req_blue];
         pxr_ff <= PW'(lr_ff) * PW'(4124);
         pxg_ff <= PW'(lg_ff) * PW'(3576);
         pxb_ff <= PW'(lb_ff) * PW'(1805);
         pyr_ff <= PW'(lr_ff) * PW'(2126);
         pyg_ff <= PW'(lg_ff) * PW'(7152);
         pyb_ff <= PW'(lb_ff) * PW'(722);
         pzr_ff <= PW'(lr_ff) * PW'(193);
         pzg_ff <= PW'(lg_ff) * PW'(1192);
         pzb_ff <= PW'(lb_ff) * PW'(9505);
         nx_ff  <= (sx << 3) + (sx << 1);
         ny_ff  <= s2l_pkg::NUM_W'(pyr_ff) + s2l_pkg::NUM_W'(pyg_ff)
                   + s2l_pkg::NUM_W'(pyb_ff);
         nz_ff  <= (sz << 3) + (sz << 1);
      end
   end

   logic [s2l_pkg::V_W-1:0] vx, vy, vz;
   logic [s2l_pkg::F_W-1:0] fx, fy, fz;

   s2l_cdiv #(.NUM_W(s2l_pkg::NUM_W), .QUO_W(s2l_pkg::V_W), .DIVISOR(95047)) u_div_x (
      .clock(clock), .en(en), .num_in(nx_ff), .quo_out(vx));
   s2l_cdiv #(.NUM_W(s2l_pkg::NUM_W), .QUO_W(s2l_pkg::V_W), .DIVISOR(10000)) u_div_y (
      .clock(clock), .en(en), .num_in(ny_ff), .quo_out(vy));
   s2l_cdiv #(.NUM_W(s2l_pkg::NUM_W), .QUO_W(s2l_pkg::V_W), .DIVISOR(108883)) u_div_z (
      .clock(clock), .en(en), .num_in(nz_ff), .quo_out(vz));

   s2l_compand u_cmp_x (.clock(clock), .en(en), .v_in(vx), .f_out(fx));
   s2l_compand u_cmp_y (.clock(clock), .en(en), .v_in(vy), .f_out(fy));
   s2l_compand u_cmp_z (.clock(clock), .en(en), .v_in(vz), .f_out(fz));

   logic signed [43:0] fxs, fys, fzs;
   logic signed [43:0] lm_ff, am_ff, bm_ff;
   logic signed [43:0] lq, aq, bq;

   assign fxs = $signed({12'd0, fx});
   assign fys = $signed({12'd0, fy});
   assign fzs = $signed({12'd0, fz});
   // Adding half an output step before the arithmetic shift rounds ties upward.
   assign lq  = (lm_ff + (44'sd1 <<< 21)) >>> 22;
   assign aq  = (am_ff + (44'sd1 <<< 21)) >>> 22;
   assign bq  = (bm_ff + (44'sd1 <<< 21)) >>> 22;

   logic [14:0] l_ff;
   logic [15:0] a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lm_ff <= 44'sd116 * fys - (44'sd16 <<< 30);
         am_ff <= 44'sd500 * (fxs - fys);
         bm_ff <= 44'sd200 * (fys - fzs);
         if (lq < 44'sd0) begin
            l_ff <= '0;
         end else if (lq > 44'sd25600) begin
            l_ff <= 15'd25600;
         end else begin
            l_ff <= lq[14:0];
         end
         if (aq > 44'sd32767) begin
            a_ff <= 16'h7FFF;
         end else if (aq < -44'sd32768) begin
            a_ff <= 16'h8000;
         end else begin
            a_ff <= aq[15:0];
         end
         if (bq > 44'sd32767) begin
            b_ff <= 16'h7FFF;
         end else if (bq < -44'sd32768) begin
            b_ff <= 16'h8000;
         end else begin
            b_ff <= bq[15:0];
         end
      end
   end

   assign rsp_lightness        = l_ff;
   assign rsp_green_red_axis   = a_ff;
   assign rsp_blue_yellow_axis = b_ff;
endmodule

>>> hdl/srgb_to_cielab_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srgb_to_cielab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_lightness,
   input logic [15:0] rsp_green_red_axis,
   input logic [15:0] rsp_blue_yellow_axis
);
   logic [46:0] rsp_beat;

   assign rsp_beat = {rsp_lightness, rsp_green_red_axis, rsp_blue_yellow_axis};

   // The response beat holds while the receiver stalls.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_beat))
   // Back-pressure only comes from a stalled response.
   `ASSERT_SAME(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ASSERT_SAME(a_l_range, clock, reset, rsp_valid, rsp_lightness <= 15'd25600)
endmodule

bind srgb_to_cielab srgb_to_cielab_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_lightness       (rsp_lightness),
   .rsp_green_red_axis  (rsp_green_red_axis),
   .rsp_blue_yellow_axis(rsp_blue_yellow_axis)
);

>>> test/srgb_to_cielab_test.sv
`timescale 1ns / 1ps
module srgb_to_cielab_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_lightness;
   logic [15:0] rsp_green_red_axis;
   logic [15:0] rsp_blue_yellow_axis;

   typedef struct packed {
      logic [14:0] lightness;
      logic [15:0] green_red_axis;
      logic [15:0] blue_yellow_axis;
   } lab_type;

   lab_type     lab_queue[$];
   int          error_count = 0;
   int          pixel_count = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          hold_cycles = 0;
   logic [30:0] linear_table [256];

   srgb_to_cielab u_top (.*);

   always #2 clock = ~clock;

   function automatic logic [63:0] fifth_power(input logic [63:0] r);
      logic [63:0] r2;
      logic [63:0] r4;
      r2 = (r * r) >> 30;
      r4 = (r2 * r2) >> 30;
      return (r4 * r) >> 30;
   endfunction

   function automatic logic [63:0] cube(input logic [63:0] r);
      logic [63:0] r2;
      r2 = (r * r) >> 30;
      return (r2 * r) >> 30;
   endfunction

   function automatic logic [63:0] decode_gamma(input logic [63:0] c);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      if (100000 * c > 64'd1031475) begin
         t  = ((1000 * c + 64'd14025) << 30) / 64'd269025;
         t2 = (t * t) >> 30;
         for (int i = 30; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if (cand <= (64'd1 << 30) && fifth_power(cand) <= t2) r = cand;
         end
         return (t2 * r) >> 30;
      end
      return ((10 * c) << 30) / 64'd32946;
   endfunction

   function automatic logic [63:0] lab_curve(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      if (v * 64'd1000000 > (64'd8856 << 30)) begin
         for (int i = 30; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if (cube(cand) <= v) r = cand;
         end
         return r;
      end
      return (64'd7787 * v) / 64'd1000 + (64'd16 << 30) / 64'd116;
   endfunction

   function automatic longint round_q22(input longint x);
      return (x + (longint'(1) << 21)) >>> 22;
   endfunction

   function automatic longint clamp16(input longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   function automatic lab_type convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      logic [63:0] lr;
      logic [63:0] lg;
      logic [63:0] lb;
      longint      fx;
      longint      fy;
      longint      fz;
      longint      l;
      longint      a;
      longint      bb;
      lab_type     res;
      lr = 64'(linear_table[r]);
      lg = 64'(linear_table[g]);
      lb = 64'(linear_table[b]);
      fx = longint'(lab_curve((64'd10 * (4124 * lr + 3576 * lg + 1805 * lb)) / 64'd95047));
      fy = longint'(lab_curve((2126 * lr + 7152 * lg + 722 * lb) / 64'd10000));
      fz = longint'(lab_curve((64'd10 * (193 * lr + 1192 * lg + 9505 * lb)) / 64'd108883));
      l  = round_q22(116 * fy - (longint'(16) << 30));
      a  = clamp16(round_q22(500 * (fx - fy)));
      bb = clamp16(round_q22(200 * (fy - fz)));
      if (l < 0) l = 0;
      if (l > 25600) l = 25600;
      res.lightness        = l[14:0];
      res.green_red_axis   = a[15:0];
      res.blue_yellow_axis = bb[15:0];
      return res;
   endfunction

   // Receiver stall, driven at the falling edge.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      lab_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lab_queue.size() == 0) begin
            $error("unexpected result beat");
            error_count++;
         end else begin
            want = lab_queue.pop_front();
            if (rsp_lightness !== want.lightness) begin
               $error("lightness: expected %0d, got %0d", want.lightness, rsp_lightness);
               error_count++;
            end
            if (rsp_green_red_axis !== want.green_red_axis) begin
               $error("green_red_axis: expected %0d, got %0d",
                      $signed(want.green_red_axis), $signed(rsp_green_red_axis));
               error_count++;
            end
            if (rsp_blue_yellow_axis !== want.blue_yellow_axis) begin
               $error("blue_yellow_axis: expected %0d, got %0d",
                      $signed(want.blue_yellow_axis), $signed(rsp_blue_yellow_axis));
               error_count++;
            end
         end
      end
   end

   // Leaves req_valid high on return; the next call or drain_results sets it at this edge.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lab_queue.push_back(convert_pixel(r, g, b));
      pixel_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (lab_queue.size() != 0) @(negedge clock);
   endtask

   task automatic test_corners();
      logic [7:0] edges [6] = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
      for (int i = 0; i < 6; i++) send_pixel(edges[i], edges[i], edges[i]);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd85, 8'd170, 8'd85);
      drain_results();
   endtask

   task automatic test_random(input int count, input int s_idle, input int r_idle);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_pixel(8'($urandom_range(12)), 8'($urandom_range(12)),
                       8'($urandom_range(12)));
         else
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // A long receiver hold fills the pipeline so that the input stalls.
   task automatic test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      hold_cycles = 300;
      for (int i = 0; i < 150; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      drain_results();
   endtask

   initial begin
      for (int c = 0; c < 256; c++) linear_table[c] = 31'(decode_gamma(64'(c)));
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corners();
      test_random(500, 38, 58);
      drain_results();
      test_random(500, 58, 38);
      drain_results();
      test_random(400, 0, 0);
      test_backpressure();
      repeat (100) @(negedge clock);
      $display("Sent %0d pixels: channel extremes, primaries, curve knees, random mixes,",
               pixel_count);
      $display("with idling on both sides and a long receiver hold.");
      if (error_count == 0 && lab_queue.size() == 0)
         $display("srgb_to_cielab_test: done, clean");
      else
         $display("srgb_to_cielab_test: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("srgb_to_cielab_test: done, errors");
      $finish;
   end

endmodule
